/* rtl/cdq_pkg.sv */
package cdq_pkg;

    // Width of the capacity register and of the operation code.
    localparam int CAP_W  = 5;
    localparam int MODE_W = 3;

    // Capacity after reset.
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_REAR  = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_REAR   = 3'd3,
        MODE_PEEK_FRONT = 3'd4,
        MODE_PEEK_REAR  = 3'd5
    } cdq_mode_t;

    // Outcome of one operation, decided in the cycle the word is taken.
    typedef struct packed {
        logic use_mem;   // value comes from the ring read
        logic neg_one;   // value is all ones (empty deque)
        logic ok;
        logic is_empty;
        logic is_full;
    } cdq_status_t;

endpackage

/* rtl/cdq_ring_mem.sv */
module cdq_ring_mem #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    parameter int ADDR_W     = 4
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [ADDR_W-1:0]     waddr,
    input  logic [DATA_WIDTH-1:0] wdata,
    input  logic                  re,
    input  logic [ADDR_W-1:0]     raddr,
    output logic [DATA_WIDTH-1:0] rdata
);

    logic [DATA_WIDTH-1:0] ring_mem [DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ring_mem[waddr] <= wdata;
        end
    end

    // Read data is registered and holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= ring_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/cdq_ctrl.sv */
module cdq_ctrl #(
    parameter int DEPTH  = 16,
    parameter int IDX_W  = 4,
    parameter int CNT_W  = 5
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [cdq_pkg::CAP_W-1:0]  cfg_capacity,
    input  logic                       step,
    input  logic [cdq_pkg::MODE_W-1:0] mode,
    output logic                       mem_we,
    output logic [IDX_W-1:0]           mem_waddr,
    output logic                       mem_re,
    output logic [IDX_W-1:0]           mem_raddr,
    output cdq_pkg::cdq_status_t       status
);

    localparam int SIZE_RESET_INT =
        (int'(cdq_pkg::CAP_RESET) > DEPTH) ? DEPTH : int'(cdq_pkg::CAP_RESET);
    localparam logic [CNT_W-1:0] SIZE_RESET = CNT_W'(SIZE_RESET_INT);

    logic [CNT_W-1:0] size_reg, size_next;
    logic [IDX_W-1:0] front_reg, front_next;
    logic [IDX_W-1:0] rear_reg, rear_next;
    logic             empty_reg, empty_next;

    logic [IDX_W-1:0] last_idx;
    logic [IDX_W-1:0] front_inc, front_dec, rear_inc, rear_dec, rear_next_inc;
    logic             full_now;
    cdq_pkg::cdq_mode_t op;

    // Capacity 0 acts as 1, and anything above DEPTH acts as DEPTH.
    always_comb
    begin
        if (cfg_capacity == '0)
        begin
            size_next = CNT_W'(1);
        end
        else if (32'(cfg_capacity) > 32'(DEPTH))
        begin
            size_next = CNT_W'(DEPTH);
        end
        else
        begin
            size_next = CNT_W'(cfg_capacity);
        end
    end

    assign last_idx  = IDX_W'(size_reg - CNT_W'(1));
    assign front_inc = ((CNT_W'(front_reg) + CNT_W'(1)) == size_reg) ? '0
                     : IDX_W'(CNT_W'(front_reg) + CNT_W'(1));
    assign rear_inc  = ((CNT_W'(rear_reg) + CNT_W'(1)) == size_reg) ? '0
                     : IDX_W'(CNT_W'(rear_reg) + CNT_W'(1));
    assign front_dec = (front_reg == '0) ? last_idx : front_reg - IDX_W'(1);
    assign rear_dec  = (rear_reg == '0) ? last_idx : rear_reg - IDX_W'(1);
    assign full_now  = !empty_reg && (rear_inc == front_reg);
    assign op        = cdq_pkg::cdq_mode_t'(mode);

    always_comb
    begin
        front_next       = front_reg;
        rear_next        = rear_reg;
        empty_next       = empty_reg;
        mem_we           = 1'b0;
        mem_waddr        = '0;
        mem_re           = 1'b0;
        mem_raddr        = front_reg;
        status.use_mem   = 1'b0;
        status.neg_one   = 1'b0;
        status.ok        = 1'b0;
        case (op)
            cdq_pkg::MODE_PUSH_FRONT, cdq_pkg::MODE_PUSH_REAR:
            begin
                if (!full_now)
                begin
                    status.ok = 1'b1;
                    mem_we    = step;
                    if (empty_reg)
                    begin
                        // First element always lands at position zero.
                        front_next = '0;
                        rear_next  = '0;
                        empty_next = 1'b0;
                        mem_waddr  = '0;
                    end
                    else if (op == cdq_pkg::MODE_PUSH_FRONT)
                    begin
                        front_next = front_dec;
                        mem_waddr  = front_dec;
                    end
                    else
                    begin
                        rear_next = rear_inc;
                        mem_waddr = rear_inc;
                    end
                end
            end
            cdq_pkg::MODE_POP_FRONT, cdq_pkg::MODE_POP_REAR,
            cdq_pkg::MODE_PEEK_FRONT, cdq_pkg::MODE_PEEK_REAR:
            begin
                if (empty_reg)
                begin
                    status.neg_one = 1'b1;
                end
                else
                begin
                    status.ok      = 1'b1;
                    status.use_mem = 1'b1;
                    mem_re         = step;
                    if (op == cdq_pkg::MODE_POP_FRONT || op == cdq_pkg::MODE_PEEK_FRONT)
                    begin
                        mem_raddr = front_reg;
                    end
                    else
                    begin
                        mem_raddr = rear_reg;
                    end
                    if (op == cdq_pkg::MODE_POP_FRONT || op == cdq_pkg::MODE_POP_REAR)
                    begin
                        if (front_reg == rear_reg)
                        begin
                            front_next = '0;
                            rear_next  = '0;
                            empty_next = 1'b1;
                        end
                        else if (op == cdq_pkg::MODE_POP_FRONT)
                        begin
                            front_next = front_inc;
                        end
                        else
                        begin
                            rear_next = rear_dec;
                        end
                    end
                end
            end
            default:
            begin
                // Unused codes leave the deque as it is.
            end
        endcase

        // Flags as they stand after the operation.
        rear_next_inc = ((CNT_W'(rear_next) + CNT_W'(1)) == size_reg) ? '0
                      : IDX_W'(CNT_W'(rear_next) + CNT_W'(1));
        status.is_empty = empty_next;
        status.is_full  = !empty_next && (rear_next_inc == front_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg  <= SIZE_RESET;
            front_reg <= '0;
            rear_reg  <= '0;
            empty_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            size_reg  <= size_next;
            front_reg <= '0;
            rear_reg  <= '0;
            empty_reg <= 1'b1;
        end
        else if (step)
        begin
            front_reg <= front_next;
            rear_reg  <= rear_next;
            empty_reg <= empty_next;
        end
    end

`ifndef SYNTHESIS
    a_empty_at_origin: assert property (@(posedge clk) disable iff (!rst_n)
        empty_reg |-> (front_reg == '0 && rear_reg == '0))
        else $error("empty deque with pointers away from zero");

    a_ptr_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        (CNT_W'(front_reg) < size_reg) && (CNT_W'(rear_reg) < size_reg))
        else $error("ring pointer beyond configured size");
`endif

endmodule

/* rtl/circular_deque_unit.sv */
// Double-ended queue of signed words held in a ring memory.
//
// Input channel (in_valid/in_ready): one word carries an operation code in
// mode and, for pushes, the word to store in value_in. Output channel
// (out_valid/out_ready): one result word per input word with value_out, ok
// and the is_empty/is_full flags as they stand after the operation.
// Configuration channel (cfg_valid/cfg_ready): writes the ring capacity and
// empties the deque; it is always ready and is meant to be used while no
// operation is in flight.
//
// Flow: the pointer update and the ring memory access happen when the input
// word is accepted, the registered memory read waits beside the holding
// stage, and the result then moves to the output register, which drives
// out_valid. One word per cycle is sustained while the receiver takes
// results, since every operation touches one ring entry once. When out_ready
// is low the output register and the holding stage fill and in_ready drops;
// nothing is lost. After reset the deque is empty and the capacity is 16
// entries (or DEPTH if smaller).
module circular_deque_unit #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cdq_pkg::CAP_W-1:0]         capacity,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [cdq_pkg::MODE_W-1:0]        mode,
    input  logic signed [DATA_WIDTH-1:0]      value_in,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [DATA_WIDTH-1:0]      value_out,
    output logic                              ok,
    output logic                              is_empty,
    output logic                              is_full
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                  accept;
    logic                  advance;
    logic                  mem_we, mem_re;
    logic [IDX_W-1:0]      mem_waddr, mem_raddr;
    logic [DATA_WIDTH-1:0] mem_rdata;
    cdq_pkg::cdq_status_t  step_status;

    // Holding stage: waits for the registered memory read.
    logic                  hold_valid_reg, hold_valid_next;
    cdq_pkg::cdq_status_t  hold_status_reg;

    // Output register.
    logic                  out_valid_reg, out_valid_next;
    logic [DATA_WIDTH-1:0] value_out_reg;
    logic                  ok_reg, is_empty_reg, is_full_reg;

    assign cfg_ready = 1'b1;
    assign advance   = hold_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !hold_valid_reg || advance;
    assign accept    = in_valid && in_ready;

    cdq_ctrl #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_capacity (capacity),
        .step         (accept),
        .mode         (mode),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_re       (mem_re),
        .mem_raddr    (mem_raddr),
        .status       (step_status)
    );

    cdq_ring_mem #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .ADDR_W     (IDX_W)
    ) u_ring (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (value_in),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (accept)
        begin
            hold_valid_next = 1'b1;
        end
        else if (advance)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_status_reg <= step_status;
        end
    end

    // The memory read data is valid here because no new read is issued
    // while the holding stage is occupied and cannot advance.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (hold_status_reg.use_mem)
            begin
                value_out_reg <= mem_rdata;
            end
            else if (hold_status_reg.neg_one)
            begin
                value_out_reg <= '1;
            end
            else
            begin
                value_out_reg <= '0;
            end
            ok_reg       <= hold_status_reg.ok;
            is_empty_reg <= hold_status_reg.is_empty;
            is_full_reg  <= hold_status_reg.is_full;
        end
    end

    assign out_valid = out_valid_reg;
    assign value_out = value_out_reg;
    assign ok        = ok_reg;
    assign is_empty  = is_empty_reg;
    assign is_full   = is_full_reg;

`ifndef SYNTHESIS
    a_hold_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (hold_valid_reg && !advance) |=> (hold_valid_reg && $stable(mem_rdata)))
        else $error("holding stage lost its word during a stall");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(is_empty_reg && is_full_reg))
        else $error("result reports both empty and full");

    a_no_read_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (hold_valid_reg && !advance) |-> !mem_re)
        else $error("ring read issued while holding stage is blocked");
`endif

endmodule
